### src/well512_generator_assert.svh
// assertion macros for the well512 generator
`ifndef WELL512_GENERATOR_ASSERT_SVH
`define WELL512_GENERATOR_ASSERT_SVH

`ifndef SYNTH

// check that is masked while reset is high
`define WELL512_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("well512_generator: check failed");

// check that also holds across reset
`define WELL512_CHECK_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("well512_generator: reset check failed");

`else

`define WELL512_CHECK(lbl, prop)
`define WELL512_CHECK_RST(lbl, prop)

`endif

`endif

### src/well512_pkg.sv
// types, constants and microcode table of the well512 generator
`timescale 1ns / 1ps

package well512_pkg;

   localparam int POOL_WORDS = 16;
   localparam int POS_W      = $clog2(POOL_WORDS);
   localparam int WORD_W     = 32;

   localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA44_2D24;
   localparam logic [WORD_W-1:0] MIX_ADD     = 32'h7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_MUL1    = 32'h1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL2    = 32'h1331_11EB;

   localparam logic [POS_W-1:0] OFS_13   = POS_W'(13);
   localparam logic [POS_W-1:0] OFS_9    = POS_W'(9);
   localparam logic [POS_W-1:0] CNT_LAST = POS_W'(POOL_WORDS - 1);

   localparam logic CMD_RESEED = 1'b0;
   localparam logic CMD_DRAW   = 1'b1;

   // microcode step addresses
   typedef enum logic [3:0] {
      ST_SEED_ADD  = 4'd0,
      ST_SEED_MIX1 = 4'd1,
      ST_SEED_MIX2 = 4'd2,
      ST_SEED_FIN  = 4'd3,
      ST_SEED_FILL = 4'd4,
      ST_DRAW_RD0  = 4'd5,
      ST_DRAW_RD13 = 4'd6,
      ST_DRAW_RD9  = 4'd7,
      ST_DRAW_RD15 = 4'd8,
      ST_DRAW_UPD  = 4'd9,
      ST_DRAW_OUT  = 4'd10
   } step_type;

   typedef enum logic [1:0] {RD_P, RD_P13, RD_P9, RD_P15} rd_sel_type;
   typedef enum logic [1:0] {CAP_NONE, CAP_A, CAP_B, CAP_C} cap_sel_type;
   typedef enum logic [2:0] {
      ACC_HOLD, ACC_ADD, ACC_MUL1, ACC_MUL2, ACC_FIN, ACC_NV0
   } acc_op_type;
   typedef enum logic [1:0] {WR_NONE, WR_CNT, WR_P_NV1, WR_Q_ACC} wr_sel_type;
   typedef enum logic [1:0] {JMP_NEXT, JMP_LOOP, JMP_END} jmp_type;

   typedef struct packed {
      rd_sel_type  rd_sel;
      cap_sel_type cap_sel;
      acc_op_type  acc_op;
      wr_sel_type  wr_sel;
      logic        cnt_clr;
      logic        cnt_inc;
      logic        pos_step;
      logic        emit;
      jmp_type     jmp;
      step_type    target;
   } ctrl_word_type;

   // sequencer to datapath
   typedef struct packed {
      logic          load;
      logic          fire;
      ctrl_word_type cw;
   } dp_ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic cnt_last;
      logic out_full;
   } dp_status_type;

   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type cw;
      cw = '{rd_sel: RD_P, cap_sel: CAP_NONE, acc_op: ACC_HOLD, wr_sel: WR_NONE,
             cnt_clr: 1'b0, cnt_inc: 1'b0, pos_step: 1'b0, emit: 1'b0,
             jmp: JMP_NEXT, target: ST_SEED_ADD};
      unique case (step)
         ST_SEED_ADD: begin
            cw.acc_op  = ACC_ADD;
            cw.cnt_clr = 1'b1;
         end
         ST_SEED_MIX1: cw.acc_op = ACC_MUL1;
         ST_SEED_MIX2: cw.acc_op = ACC_MUL2;
         ST_SEED_FIN:  cw.acc_op = ACC_FIN;
         ST_SEED_FILL: begin
            cw.wr_sel  = WR_CNT;
            cw.cnt_inc = 1'b1;
            cw.jmp     = JMP_LOOP;
            cw.target  = ST_SEED_FILL;
         end
         ST_DRAW_RD0:  cw.rd_sel = RD_P;
         ST_DRAW_RD13: begin
            cw.rd_sel  = RD_P13;
            cw.cap_sel = CAP_A;
         end
         ST_DRAW_RD9: begin
            cw.rd_sel  = RD_P9;
            cw.cap_sel = CAP_B;
         end
         ST_DRAW_RD15: begin
            cw.rd_sel  = RD_P15;
            cw.cap_sel = CAP_C;
         end
         ST_DRAW_UPD: begin
            cw.acc_op = ACC_NV0;
            cw.wr_sel = WR_P_NV1;
         end
         ST_DRAW_OUT: begin
            cw.wr_sel   = WR_Q_ACC;
            cw.pos_step = 1'b1;
            cw.emit     = 1'b1;
            cw.jmp      = JMP_END;
         end
         default: cw.jmp = JMP_END;
      endcase
      return cw;
   endfunction

endpackage

### src/well512_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module well512_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/well512_seq.sv
// microcode sequencer: step counter, control table and jumps
`timescale 1ns / 1ps

module well512_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  well512_pkg::dp_status_type status,
   output well512_pkg::dp_ctrl_type   ctrl
);

   logic                  busy_ff, busy_in;
   well512_pkg::step_type upc_ff, upc_in;
   well512_pkg::ctrl_word_type cw;
   logic                  accept;
   logic                  fire;

   assign cw        = well512_pkg::ucode_rom(upc_ff);
   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;
   // an emitting step waits while the output beat is still held
   assign fire      = busy_ff && !(cw.emit && status.out_full);

   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (accept) begin
         busy_in = 1'b1;
         upc_in  = (req_cmd == well512_pkg::CMD_DRAW) ? well512_pkg::ST_DRAW_RD0
                                                      : well512_pkg::ST_SEED_ADD;
      end else if (fire) begin
         unique case (cw.jmp)
            well512_pkg::JMP_NEXT: upc_in = well512_pkg::step_type'(upc_ff + 4'd1);
            well512_pkg::JMP_LOOP: begin
               if (status.cnt_last) begin
                  busy_in = 1'b0;
               end else begin
                  upc_in = cw.target;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // reset runs the reseed program with a zero seed
         busy_ff <= 1'b1;
         upc_ff  <= well512_pkg::ST_SEED_ADD;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   assign ctrl.load = accept;
   assign ctrl.fire = fire;
   assign ctrl.cw   = cw;

endmodule

### src/well512_dp.sv
// datapath: pool ram, operand registers, mixer and output register
`timescale 1ns / 1ps

module well512_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  well512_pkg::dp_ctrl_type               ctrl,
   output well512_pkg::dp_status_type             status,
   input  logic [31:0]                           req_seed,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [31:0]                           rsp_value
);

   localparam int PW = well512_pkg::POS_W;
   localparam int WW = well512_pkg::WORD_W;

   logic [WW-1:0] acc_ff, acc_in;
   logic [WW-1:0] a_ff, b_ff, c_ff;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic          out_valid_ff, out_valid_in;
   logic [WW-1:0] out_value_ff;

   logic [PW-1:0] pos_q;
   logic [PW-1:0] rd_addr, wr_addr;
   logic [WW-1:0] rd_data, wr_data;
   logic          wr_en;
   logic [WW-1:0] z1, z2, nv1, dmix, nv0;
   logic [WW-1:0] mul_a, mul_k, prod;

   assign pos_q = pos_ff - PW'(1);

   well512_ram #(.WIDTH(WW), .DEPTH(well512_pkg::POOL_WORDS)) u_pool (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      unique case (ctrl.cw.rd_sel)
         well512_pkg::RD_P13: rd_addr = pos_ff + well512_pkg::OFS_13;
         well512_pkg::RD_P9:  rd_addr = pos_ff + well512_pkg::OFS_9;
         well512_pkg::RD_P15: rd_addr = pos_q;
         default:             rd_addr = pos_ff;
      endcase
   end

   // recurrence; rd_data holds the word one step back from the current position
   assign z1   = a_ff ^ b_ff ^ (a_ff << 16) ^ (b_ff << 15);
   assign z2   = c_ff ^ (c_ff >> 11);
   assign nv1  = z1 ^ z2;
   assign dmix = nv1 ^ ((nv1 << 5) & well512_pkg::TEMPER_MASK);
   assign nv0  = rd_data ^ z1 ^ dmix ^ (rd_data << 2) ^ (z1 << 18) ^ (z2 << 28);

   // one shared multiplier for both scramble rounds
   assign mul_a = (ctrl.cw.acc_op == well512_pkg::ACC_MUL1) ? (acc_ff ^ (acc_ff >> 15))
                                                          : (acc_ff ^ (acc_ff >> 13));
   assign mul_k = (ctrl.cw.acc_op == well512_pkg::ACC_MUL1) ? well512_pkg::MIX_MUL1
                                                          : well512_pkg::MIX_MUL2;
   assign prod  = mul_a * mul_k;

   always_comb begin
      wr_en   = ctrl.fire && (ctrl.cw.wr_sel != well512_pkg::WR_NONE);
      wr_addr = cnt_ff;
      wr_data = acc_ff;
      unique case (ctrl.cw.wr_sel)
         well512_pkg::WR_P_NV1: begin
            wr_addr = pos_ff;
            wr_data = nv1;
         end
         well512_pkg::WR_Q_ACC: wr_addr = pos_q;
         default: ;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = req_seed;
      end else if (ctrl.fire) begin
         unique case (ctrl.cw.acc_op)
            well512_pkg::ACC_ADD:  acc_in = acc_ff + well512_pkg::MIX_ADD;
            well512_pkg::ACC_MUL1,
            well512_pkg::ACC_MUL2: acc_in = prod;
            well512_pkg::ACC_FIN:  acc_in = acc_ff ^ (acc_ff >> 15);
            well512_pkg::ACC_NV0:  acc_in = nv0;
            default:               acc_in = acc_ff;
         endcase
      end
   end

   always_comb begin
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      if (ctrl.fire && ctrl.cw.pos_step) begin
         pos_in = pos_q;
      end
      if (ctrl.fire && ctrl.cw.cnt_clr) begin
         cnt_in = '0;
      end else if (ctrl.fire && ctrl.cw.cnt_inc) begin
         cnt_in = cnt_ff + PW'(1);
      end
      out_valid_in = out_valid_ff && !rsp_ready;
      if (ctrl.fire && ctrl.cw.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.fire && ctrl.cw.cap_sel == well512_pkg::CAP_A) begin
         a_ff <= rd_data;
      end
      if (ctrl.fire && ctrl.cw.cap_sel == well512_pkg::CAP_B) begin
         b_ff <= rd_data;
      end
      if (ctrl.fire && ctrl.cw.cap_sel == well512_pkg::CAP_C) begin
         c_ff <= rd_data;
      end
      if (ctrl.fire && ctrl.cw.emit) begin
         out_value_ff <= acc_ff;
      end
   end

   assign status.cnt_last = (cnt_ff == well512_pkg::CNT_LAST);
   assign status.out_full = out_valid_ff && !rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_value_ff;

endmodule

### src/well512_generator.sv
// top level of the well512 random word generator
// draw: one result beat per accepted beat; the next beat is taken only once the draw program ends
// reseed: 4 scramble steps and 16 pool writes of sequencer work, no result
// pace is set by the single read port of the pool ram and the microcode walk
// reset: synchronous; runs a reseed with seed zero, req_ready low meanwhile
// position resets to zero; result register empty after reset
`timescale 1ns / 1ps

`include "well512_generator_assert.svh"

module well512_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value
);

   // control word and handshake strobes from the sequencer
   well512_pkg::dp_ctrl_type   dp_ctrl;
   // loop and back-pressure flags from the datapath
   well512_pkg::dp_status_type dp_status;

   // step counter plus microcode table; walks the reseed or draw program
   well512_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd  (req_cmd),
      .status   (dp_status),
      .ctrl     (dp_ctrl)
   );

   // pool ram, operand registers, scramble multiplier and result register
   well512_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (dp_ctrl),
      .status   (dp_status),
      .req_seed (req_seed),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_value(rsp_value)
   );

   // a result beat only appears after the emitting step of a draw
   `WELL512_CHECK(a_rsp_from_emit, $rose(rsp_valid) |-> $past(dp_ctrl.fire && dp_ctrl.cw.emit))
   // a held result beat is never overwritten by a new draw
   `WELL512_CHECK(a_no_overwrite, (rsp_valid && !rsp_ready) |-> !(dp_ctrl.fire && dp_ctrl.cw.emit))
   // the reset reseed pass keeps the input closed right after reset
   `WELL512_CHECK_RST(a_reset_busy, reset |=> !req_ready)

endmodule

### dv/tb_top.sv
// self-checking testbench for the well512 random word generator
`timescale 1ns / 1ps

module tb_top;

   // scramble and recurrence constants, kept local to the predictor
   localparam logic [31:0] SCR_ADD  = 32'h7F4A_7C15;
   localparam logic [31:0] SCR_MUL1 = 32'h1CE4_E5B9;
   localparam logic [31:0] SCR_MUL2 = 32'h1331_11EB;
   localparam logic [31:0] TEMPER   = 32'hDA44_2D24;

   // seed whose scramble input wraps to zero, so the whole pool collapses to zero
   localparam logic [31:0] ZERO_POOL_SEED = 32'h80B5_83EB;

   localparam int RANDOM_BEATS  = 1300;
   localparam int TAIL_BEATS    = 150;   // no idling on either side here
   localparam int HOLD_AT_BEAT  = 300;   // receiver holds off once, from here
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_AT_BEAT = 700;   // sender waits for every result once
   localparam int SETTLE_CYCLES = 40;    // covers a trailing reseed
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_MAX    = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = well512_pkg::CMD_DRAW;
   logic [31:0] req_seed = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_value;

   // predictor state: pool words and circular position
   logic [31:0] well_pool [well512_pkg::POOL_WORDS];
   logic [3:0]  well_pos;

   // words still owed by the block, oldest first
   logic [31:0] drawn_words [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   bit quiet_tail     = 1'b0;
   bit hold_rsp_now   = 1'b0;

   // directed rows; value is typed in only where it is obvious (zero pool)
   typedef struct {
      logic        cmd;
      logic [31:0] seed;
      bit          typed;
      logic [31:0] value;
   } stim_row_type;

   stim_row_type directed_rows [24] = '{
      // draws straight after reset, first one wraps position 0 to 15
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      // seed field must be ignored by a draw
      '{well512_pkg::CMD_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      // reseed to the reset seed, position kept
      '{well512_pkg::CMD_RESEED, 32'h0000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_RESEED, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      // back to back reseeds, last one wins
      '{well512_pkg::CMD_RESEED, 32'h8000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_RESEED, 32'h0000_0001, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h5555_5555, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'hAAAA_AAAA, 1'b0, 32'h0},
      // all-zero pool stays zero under the recurrence
      '{well512_pkg::CMD_RESEED, ZERO_POOL_SEED, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b1, 32'h0000_0000},
      '{well512_pkg::CMD_DRAW,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
      '{well512_pkg::CMD_RESEED, 32'h1234_5678, 1'b0, 32'h0},
      // enough draws to take the position around the pool again
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{well512_pkg::CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0}
   };

   well512_generator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .req_seed  (req_seed),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // 32-bit seed scramble, every add and product wraps
   function automatic logic [31:0] scramble_word(input logic [31:0] x);
      logic [31:0] t;
      t = x + SCR_ADD;
      t = (t ^ (t >> 15)) * SCR_MUL1;
      t = (t ^ (t >> 13)) * SCR_MUL2;
      return t ^ (t >> 15);
   endfunction

   function automatic void reseed_pool(input logic [31:0] seed);
      logic [31:0] w;
      w = scramble_word(seed);
      for (int i = 0; i < well512_pkg::POOL_WORDS; i++) well_pool[i] = w;
   endfunction

   // one step of the recurrence; rewrites two words, moves position back by one
   function automatic logic [31:0] draw_next();
      logic [3:0]  p, q;
      logic [31:0] v0, v13, v9, z1, z2, nv1, d, old, nv0;
      p   = well_pos;
      v0  = well_pool[p];
      v13 = well_pool[4'(p + 4'd13)];
      v9  = well_pool[4'(p + 4'd9)];
      z1  = v0 ^ v13 ^ (v0 << 16) ^ (v13 << 15);
      z2  = v9 ^ (v9 >> 11);
      nv1 = z1 ^ z2;
      d   = nv1 ^ ((nv1 << 5) & TEMPER);
      well_pool[p] = nv1;
      q   = 4'(p + 4'd15);
      old = well_pool[q];
      nv0 = old ^ z1 ^ d ^ (old << 2) ^ (z1 << 18) ^ (z2 << 28);
      well_pool[q] = nv0;
      well_pos = q;
      return nv0;
   endfunction

   // present one beat, hold it until taken, then update the predictor
   task automatic offer_beat(input logic cmd, input logic [31:0] seed,
                             input bit typed, input logic [31:0] typed_value);
      logic [31:0] predicted;
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_seed  <= seed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == well512_pkg::CMD_DRAW) begin
         predicted = draw_next();
         drawn_words.push_back(typed ? typed_value : predicted);
      end else begin
         reseed_pool(seed);
      end
   endtask

   // random gap after a beat; once valid is dropped, the gap is never empty
   task automatic sender_gap();
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // stimulus: reset, directed table, random stream, drain
   initial begin : drive_requests
      logic        cmd;
      logic [31:0] seed;
      int          pick;

      // reset state of the predictor matches the block's reset reseed
      well_pos = '0;
      reseed_pool(32'h0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer_beat(directed_rows[i].cmd, directed_rows[i].seed,
                    directed_rows[i].typed, directed_rows[i].value);
         sender_gap();
      end

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == RANDOM_BEATS - TAIL_BEATS) quiet_tail = 1'b1;
         // long receiver stall while the sender keeps pushing draws
         if (n == HOLD_AT_BEAT) hold_rsp_now = 1'b1;
         // sender pause until nothing is owed
         if (n == DRAIN_AT_BEAT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (drawn_words.size() != 0);
         end

         // mostly draws; reseeds now and then, seed extremes now and then
         cmd  = ($urandom_range(0, 7) == 0) ? well512_pkg::CMD_RESEED
                                            : well512_pkg::CMD_DRAW;
         pick = $urandom_range(0, 19);
         if (pick == 0)      seed = 32'h0000_0000;
         else if (pick == 1) seed = 32'hFFFF_FFFF;
         else                seed = $urandom;
         offer_beat(cmd, seed, 1'b0, 32'h0);
         sender_gap();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (drawn_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && drawn_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // result side backpressure: short random bursts, one long hold
   initial begin : drive_rsp_ready
      int hold_count;
      @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_rsp_now) begin
            hold_rsp_now = 1'b0;
            rsp_ready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            rsp_ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each result beat with the oldest owed word
   always @(posedge clock) begin : check_results
      logic [31:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drawn_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result beat: value %h", rsp_value);
         end else begin
            want = drawn_words.pop_front();
            if (rsp_value !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("value mismatch: expected %h, got %h", want, rsp_value);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
